>>> src/crcfe_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame encoder.
// Used by every module of the encoder; depends on nothing.
`default_nettype none

package crcfe_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  // Beat positions within one job. A data job enters at BEAT_BODY.
  localparam logic [2:0] BEAT_SYNC1  = 3'd0;
  localparam logic [2:0] BEAT_SYNC2  = 3'd1;
  localparam logic [2:0] BEAT_TYPE   = 3'd2;
  localparam logic [2:0] BEAT_BODY   = 3'd3;
  localparam logic [2:0] BEAT_CRC_LO = 3'd4;
  localparam logic [2:0] BEAT_CRC_HI = 3'd5;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_START,
    JOB_DATA
  } job_kind_t;

  // One classified input item, as handed from the front to the back.
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  msg_type;
    logic [7:0]  body;     // length byte of a start, data byte of a payload item
    logic        close;    // append the CRC after the body byte
    logic [15:0] crc;
  } job_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] max_payload;
  } cfg_regs_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    int i;
    c = crc_in ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/crcfe_in_if.sv
// Input item channel of the frame encoder: valid/ready plus item fields.
// Depends on nothing.
`default_nettype none

interface crcfe_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] msg_type;
  logic [7:0] payload_len;
  logic [7:0] data_byte;

  modport source (output valid, start_req, msg_type, payload_len, data_byte,
                  input ready);
  modport sink (input valid, start_req, msg_type, payload_len, data_byte,
                output ready);
endinterface

`default_nettype wire

>>> src/crcfe_out_if.sv
// Result channel of the frame encoder: valid/ready plus one frame byte.
// Depends on nothing.
`default_nettype none

interface crcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       error;

  modport source (output valid, out_byte, frame_end, error, input ready);
  modport sink (input valid, out_byte, frame_end, error, output ready);
endinterface

`default_nettype wire

>>> src/crcfe_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`default_nettype none

interface crcfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/crc16_frame_encoder.sv
// Top level of the CRC-16 frame encoder: configuration registers, front end,
// job queue and back end. Depends on crcfe_pkg, the channel interfaces and
// crcfe_front, crcfe_queue, crcfe_back.
//
//   channel   role   beat carries
//   items     sink   start_req, msg_type, payload_len, data_byte
//   results   source out_byte, frame_end, error
//   cfg       sink   index, data (register write)
//
// An item is taken in the cycle it arrives whenever the job queue has room, so
// items can enter on consecutive cycles. The back end emits one beat per
// unstalled cycle from a registered output stage: a start gives four beats
// (six for an empty payload), a payload byte one beat (three on the last
// byte), a rejected item one beat. Sustained rate is set by the beat count.
// Reset clears the frame state, the queue and the output stage, and sets the
// registers to 0xAA, 0x55 and 255. Configuration writes are taken every cycle.
`default_nettype none

module crc16_frame_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  crcfe_in_if.sink    items,
  crcfe_out_if.source results,
  crcfe_cfg_if.sink   cfg
);

  crcfe_pkg::cfg_regs_t regs;
  crcfe_pkg::job_t      push_job;
  crcfe_pkg::job_t      head_job;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_first  <= 8'hAA;
      regs.sync_second <= 8'h55;
      regs.max_payload <= 8'hFF;
    end else if (cfg.valid) begin
      case (cfg.index)
        crcfe_pkg::REG_SYNC_FIRST:  regs.sync_first  <= cfg.data;
        crcfe_pkg::REG_SYNC_SECOND: regs.sync_second <= cfg.data;
        crcfe_pkg::REG_MAX_PAYLOAD: regs.max_payload <= cfg.data;
        default: ;
      endcase
    end
  end

  crcfe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .cfg    (regs),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  crcfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  crcfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_head  (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

`default_nettype wire

>>> src/crcfe_front.sv
// Front end: accepts input items, tracks the open frame and the running CRC,
// and pushes one classified job per item. Depends on crcfe_pkg, crcfe_in_if.
`default_nettype none

module crcfe_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  crcfe_in_if.sink                  items,
  input  wire crcfe_pkg::cfg_regs_t cfg,
  input  wire logic                 q_full,
  output logic                      q_push,
  output crcfe_pkg::job_t           q_job
);

  logic        in_frame;
  logic [7:0]  bytes_left;
  logic [15:0] running_crc;

  logic        in_frame_next;
  logic [7:0]  bytes_left_next;
  logic [15:0] running_crc_next;
  logic [15:0] crc_new;
  logic [7:0]  left_dec;

  assign items.ready = !q_full;
  assign q_push      = items.valid && !q_full;
  assign left_dec    = bytes_left - 8'd1;

  always_comb begin
    in_frame_next    = in_frame;
    bytes_left_next  = bytes_left;
    running_crc_next = running_crc;
    q_job.kind       = crcfe_pkg::JOB_ERR;
    q_job.msg_type   = items.msg_type;
    q_job.body       = items.data_byte;
    q_job.close      = 1'b0;
    crc_new          = crcfe_pkg::crc16_byte(running_crc, items.data_byte);
    if (items.start_req) begin
      crc_new = crcfe_pkg::crc16_byte(
                  crcfe_pkg::crc16_byte(crcfe_pkg::CRC_INIT, items.msg_type),
                  items.payload_len);
      q_job.body = items.payload_len;
      // An oversized start is rejected and leaves any open frame as it was.
      if (items.payload_len <= cfg.max_payload) begin
        q_job.kind       = crcfe_pkg::JOB_START;
        q_job.close      = (items.payload_len == 8'd0);
        running_crc_next = crc_new;
        in_frame_next    = (items.payload_len != 8'd0);
        bytes_left_next  = items.payload_len;
      end
    end else if (in_frame) begin
      q_job.kind       = crcfe_pkg::JOB_DATA;
      q_job.close      = (left_dec == 8'd0);
      running_crc_next = crc_new;
      bytes_left_next  = left_dec;
      in_frame_next    = (left_dec != 8'd0);
    end
    q_job.crc = crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_left  <= 8'd0;
      running_crc <= crcfe_pkg::CRC_INIT;
    end else if (q_push) begin
      in_frame    <= in_frame_next;
      bytes_left  <= bytes_left_next;
      running_crc <= running_crc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/crcfe_queue.sv
// Short first-in first-out queue of jobs between the front and the back.
// Depends on crcfe_pkg.
`default_nettype none

module crcfe_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire crcfe_pkg::job_t push_job,
  input  wire logic            pop,
  output crcfe_pkg::job_t      head,
  output logic                 full,
  output logic                 empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  crcfe_pkg::job_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/crcfe_back.sv
// Back end: expands each job into frame beats, one per unstalled cycle,
// through a registered output stage. Depends on crcfe_pkg, crcfe_out_if.
`default_nettype none

module crcfe_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire crcfe_pkg::cfg_regs_t cfg,
  input  wire crcfe_pkg::job_t      q_head,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  crcfe_out_if.source               results
);

  crcfe_pkg::job_t cur;
  logic            cur_valid;
  logic [2:0]      idx;

  logic            out_valid;
  logic [7:0]      out_byte;
  logic            out_end;
  logic            out_err;

  crcfe_pkg::job_t src_job;
  logic            src_valid;
  logic [2:0]      src_idx;
  logic [7:0]      beat_byte;
  logic            beat_end;
  logic            beat_last;
  logic            load;

  assign results.valid     = out_valid;
  assign results.out_byte  = out_byte;
  assign results.frame_end = out_end;
  assign results.error     = out_err;

  assign load      = !out_valid || results.ready;
  assign src_valid = cur_valid || !q_empty;
  assign src_job   = cur_valid ? cur : q_head;
  assign q_pop     = load && !cur_valid && !q_empty;

  always_comb begin
    if (cur_valid) begin
      src_idx = idx;
    end else if (q_head.kind == crcfe_pkg::JOB_DATA) begin
      src_idx = crcfe_pkg::BEAT_BODY;
    end else begin
      src_idx = crcfe_pkg::BEAT_SYNC1;
    end
  end

  always_comb begin
    beat_end = 1'b0;
    case (src_idx)
      crcfe_pkg::BEAT_SYNC1:  beat_byte = cfg.sync_first;
      crcfe_pkg::BEAT_SYNC2:  beat_byte = cfg.sync_second;
      crcfe_pkg::BEAT_TYPE:   beat_byte = src_job.msg_type;
      crcfe_pkg::BEAT_BODY:   beat_byte = src_job.body;
      crcfe_pkg::BEAT_CRC_LO: beat_byte = src_job.crc[7:0];
      crcfe_pkg::BEAT_CRC_HI: begin
        beat_byte = src_job.crc[15:8];
        beat_end  = 1'b1;
      end
      default:                beat_byte = 8'h00;
    endcase
    beat_last = (src_idx == crcfe_pkg::BEAT_CRC_HI) ||
                (src_idx == crcfe_pkg::BEAT_BODY && !src_job.close);
    // A rejected item is a single zero beat flagged as an error.
    if (src_job.kind == crcfe_pkg::JOB_ERR) begin
      beat_byte = 8'h00;
      beat_end  = 1'b0;
      beat_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
    end else if (load) begin
      out_valid <= src_valid;
      if (src_valid) begin
        out_byte <= beat_byte;
        out_end  <= beat_end;
        out_err  <= (src_job.kind == crcfe_pkg::JOB_ERR);
        if (beat_last) begin
          cur_valid <= 1'b0;
        end else begin
          cur_valid <= 1'b1;
          cur       <= src_job;
          idx       <= src_idx + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire
